// ===== rtl/core/xsre_pkg.sv =====
// xsre_pkg: shared types and codes for the XOR shard recovery engine.
// Used by xsre_ctrl, xsre_datapath and xor_shard_recovery_engine; no dependencies.

package xsre_pkg;

   // Default sizes of the shard store
   localparam int DEF_MAX_SHARDS = 16;
   localparam int DEF_MAX_WORDS  = 1024;
   localparam int DEF_WORD_BITS  = 64;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_SHARD_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHARD_WORDS = 4'd1;
   localparam logic [4:0]  SHARD_COUNT_RESET = 5'd16;
   localparam logic [10:0] SHARD_WORDS_RESET = 11'd1024;

   // Request function codes
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_XOR   = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   // Response status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_SHARD_RANGE = 3'd1;
   localparam logic [2:0] STATUS_OUT_PRESENT = 3'd2;
   localparam logic [2:0] STATUS_SRC_MISSING = 3'd3;
   localparam logic [2:0] STATUS_WORD_RANGE  = 3'd4;

   // How a request is finished
   localparam logic [1:0] KIND_IMM  = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_XOR  = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  shard;
      logic [3:0]  source;
      logic [9:0]  word_index;
      logic [63:0] data;
      logic        first;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] read_data;
      logic        op_done;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic take;       // accept the request on the port
      logic run;        // issue reads for one xor word, advance the counter
      logic read_done;  // read data is back, post the response
      logic xor_done;   // last xor word is written back, post the response
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] kind;       // how the pending request finishes
      logic       last_word;  // counter sits on the last word of the shard
      logic       rsp_busy;   // response register full and not drained
   } dp_status_type;

endpackage

// ===== rtl/core/xsre_ctrl.sv =====
// xsre_ctrl: sequencing state machine of the XOR shard recovery engine.
// Depends on xsre_pkg for the command and status structs.

module xsre_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  xsre_pkg::dp_status_type sts,
   output xsre_pkg::cmd_type       cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_RUN   = 2'd2;
   localparam logic [1:0] S_DRAIN = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       open;

   assign open      = (state_ff == S_IDLE) && !sts.rsp_busy;
   assign req_stall = !open;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (open && req_valid) begin
               cmd.take = 1'b1;
               case (sts.kind)
                  xsre_pkg::KIND_READ: state_in = S_READ;
                  xsre_pkg::KIND_XOR:  state_in = S_RUN;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            cmd.read_done = 1'b1;
            state_in      = S_IDLE;
         end
         S_RUN: begin
            cmd.run = 1'b1;
            if (sts.last_word) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.xor_done = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/xsre_datapath.sv =====
// xsre_datapath: shard store, present flags, range checks, xor word pipe and
// response register. Depends on xsre_pkg; driven by xsre_ctrl commands.

module xsre_datapath #(
   parameter int MAX_SHARDS = xsre_pkg::DEF_MAX_SHARDS,
   parameter int MAX_WORDS  = xsre_pkg::DEF_MAX_WORDS,
   parameter int WORD_BITS  = xsre_pkg::DEF_WORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  xsre_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output xsre_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [xsre_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [xsre_pkg::CSR_DATA_W-1:0]     csr_data,
   input  xsre_pkg::cmd_type                   cmd,
   output xsre_pkg::dp_status_type             sts
);

   localparam int SHARD_W = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
   localparam int WADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int DEPTH   = MAX_SHARDS * MAX_WORDS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [SHARD_W-1:0] s,
                                                  input logic [WADDR_W-1:0] w);
      word_addr = ADDR_W'(s) * ADDR_W'(MAX_WORDS) + ADDR_W'(w);
   endfunction

   // Configuration
   logic [4:0]  shard_count_ff;
   logic [10:0] shard_words_ff;
   logic [31:0] shard_lim;
   logic [31:0] word_lim;

   // Engine state
   logic [MAX_SHARDS-1:0] present_ff;
   logic [3:0]            cur_out_ff;
   logic                  aborted_ff;
   logic [3:0]            src_ff;
   logic                  first_ff;
   logic                  last_ff;
   logic [WADDR_W-1:0]    cnt_ff;
   logic                  wr_pend_ff;
   logic [ADDR_W-1:0]     wr_addr_ff;
   logic                  rsp_valid_ff;
   xsre_pkg::rsp_type     rsp_ff;

   // Store
   logic [WORD_BITS-1:0] store_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_a_ff;
   logic [WORD_BITS-1:0] rd_b_ff;
   logic [ADDR_W-1:0]    rd_a_addr;
   logic [ADDR_W-1:0]    rd_b_addr;
   logic [ADDR_W-1:0]    req_addr;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wa;
   logic [WORD_BITS-1:0] mem_wd;

   // Request decode
   logic                 shard_ok;
   logic                 word_ok;
   logic                 src_ok;
   logic [3:0]           xor_cur;
   logic                 cur_ok;
   logic                 cur_present;
   logic                 src_present;
   logic [1:0]           d_kind;
   logic [2:0]           d_status;
   logic                 d_done;
   logic                 d_load;
   logic                 d_set;
   logic [SHARD_W-1:0]   d_set_idx;
   logic                 d_clear;
   logic                 d_abort_we;
   logic                 d_abort_val;
   logic                 d_cur_we;
   logic                 d_latch;

   assign csr_ready = 1'b1;

   assign shard_lim = (32'(shard_count_ff) < 32'(MAX_SHARDS)) ? 32'(shard_count_ff)
                                                               : 32'(MAX_SHARDS);
   assign word_lim  = (32'(shard_words_ff) < 32'(MAX_WORDS)) ? 32'(shard_words_ff)
                                                              : 32'(MAX_WORDS);

   assign shard_ok    = 32'(req_payload.shard) < shard_lim;
   assign word_ok     = 32'(req_payload.word_index) < word_lim;
   assign src_ok      = 32'(req_payload.source) < shard_lim;
   assign xor_cur     = req_payload.first ? req_payload.shard : cur_out_ff;
   assign cur_ok      = 32'(xor_cur) < shard_lim;
   assign cur_present = cur_ok && present_ff[SHARD_W'(xor_cur)];
   assign src_present = src_ok && present_ff[SHARD_W'(req_payload.source)];

   always_comb begin
      d_kind      = xsre_pkg::KIND_IMM;
      d_status    = xsre_pkg::STATUS_OK;
      d_done      = 1'b0;
      d_load      = 1'b0;
      d_set       = 1'b0;
      d_set_idx   = SHARD_W'(req_payload.shard);
      d_clear     = 1'b0;
      d_abort_we  = 1'b0;
      d_abort_val = 1'b0;
      d_cur_we    = 1'b0;
      d_latch     = 1'b0;
      case (req_payload.func)
         xsre_pkg::FUNC_LOAD: begin
            if (!shard_ok) begin
               d_status = xsre_pkg::STATUS_SHARD_RANGE;
            end else if (!word_ok) begin
               d_status = xsre_pkg::STATUS_WORD_RANGE;
            end else begin
               d_load = 1'b1;
               d_set  = req_payload.last;
               d_done = req_payload.last;
            end
         end
         xsre_pkg::FUNC_XOR: begin
            d_set_idx = SHARD_W'(xor_cur);
            if (req_payload.first) begin
               d_cur_we   = 1'b1;
               d_abort_we = 1'b1;
            end
            if (!req_payload.first && aborted_ff) begin
               d_status = xsre_pkg::STATUS_OK;
            end else if (!cur_ok || cur_present || !src_ok || !src_present) begin
               d_abort_we  = 1'b1;
               d_abort_val = 1'b1;
               if (!cur_ok) begin
                  d_status = xsre_pkg::STATUS_SHARD_RANGE;
               end else if (cur_present) begin
                  d_status = xsre_pkg::STATUS_OUT_PRESENT;
               end else if (!src_ok) begin
                  d_status = xsre_pkg::STATUS_SHARD_RANGE;
               end else begin
                  d_status = xsre_pkg::STATUS_SRC_MISSING;
               end
            end else if (word_lim == 32'd0) begin
               // empty shards: nothing to copy, finish at once
               d_set  = req_payload.last;
               d_done = req_payload.last;
            end else begin
               d_kind  = xsre_pkg::KIND_XOR;
               d_latch = 1'b1;
            end
         end
         xsre_pkg::FUNC_READ: begin
            if (!shard_ok) begin
               d_status = xsre_pkg::STATUS_SHARD_RANGE;
            end else if (!word_ok) begin
               d_status = xsre_pkg::STATUS_WORD_RANGE;
            end else begin
               d_kind = xsre_pkg::KIND_READ;
            end
         end
         default: begin
            d_clear = 1'b1;
         end
      endcase
   end

   assign sts.kind      = d_kind;
   assign sts.last_word = (32'(cnt_ff) == word_lim - 32'd1);
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;

   // Store ports: port A serves reads and xor sources, port B xor outputs
   assign req_addr  = word_addr(SHARD_W'(req_payload.shard), WADDR_W'(req_payload.word_index));
   assign rd_a_addr = cmd.run ? word_addr(SHARD_W'(src_ff), cnt_ff) : req_addr;
   assign rd_b_addr = word_addr(SHARD_W'(cur_out_ff), cnt_ff);
   assign mem_we    = wr_pend_ff || (cmd.take && d_load);
   assign mem_wa    = wr_pend_ff ? wr_addr_ff : req_addr;
   assign mem_wd    = wr_pend_ff ? (first_ff ? rd_a_ff : (rd_a_ff ^ rd_b_ff))
                                 : WORD_BITS'(req_payload.data);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
      rd_a_ff <= store_ff[rd_a_addr];
      rd_b_ff <= store_ff[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shard_count_ff <= xsre_pkg::SHARD_COUNT_RESET;
         shard_words_ff <= xsre_pkg::SHARD_WORDS_RESET;
         present_ff     <= '0;
         cur_out_ff     <= 4'd0;
         aborted_ff     <= 1'b0;
         cnt_ff         <= '0;
         wr_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == xsre_pkg::REG_SHARD_COUNT) begin
               shard_count_ff <= csr_data[4:0];
            end else if (csr_index == xsre_pkg::REG_SHARD_WORDS) begin
               shard_words_ff <= csr_data[10:0];
            end
         end
         if (cmd.take) begin
            if (d_clear) begin
               present_ff <= '0;
            end else if (d_set) begin
               present_ff[d_set_idx] <= 1'b1;
            end
            if (d_cur_we) begin
               cur_out_ff <= req_payload.shard;
            end
            if (d_abort_we) begin
               aborted_ff <= d_abort_val;
            end
            cnt_ff <= '0;
         end else if (cmd.run) begin
            cnt_ff <= cnt_ff + WADDR_W'(1);
         end
         if (cmd.xor_done && last_ff) begin
            present_ff[SHARD_W'(cur_out_ff)] <= 1'b1;
         end
         wr_pend_ff <= cmd.run;
         if ((cmd.take && d_kind == xsre_pkg::KIND_IMM) || cmd.read_done || cmd.xor_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.take && d_latch) begin
         src_ff   <= req_payload.source;
         first_ff <= req_payload.first;
         last_ff  <= req_payload.last;
      end
      if (cmd.run) begin
         wr_addr_ff <= rd_b_addr;
      end
      if (cmd.take && d_kind == xsre_pkg::KIND_IMM) begin
         rsp_ff.status    <= d_status;
         rsp_ff.read_data <= 64'd0;
         rsp_ff.op_done   <= d_done;
      end else if (cmd.read_done) begin
         rsp_ff.status    <= xsre_pkg::STATUS_OK;
         rsp_ff.read_data <= 64'(rd_a_ff);
         rsp_ff.op_done   <= 1'b0;
      end else if (cmd.xor_done) begin
         rsp_ff.status    <= xsre_pkg::STATUS_OK;
         rsp_ff.read_data <= 64'd0;
         rsp_ff.op_done   <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/xor_shard_recovery_engine.sv =====
// xor_shard_recovery_engine: top level, XOR erasure-code recovery over a shard store.
// Depends on xsre_pkg, xsre_ctrl and xsre_datapath.
//
//  channel | ports                                  | direction | handshake
//  --------+----------------------------------------+-----------+-----------------------
//  request | req_valid, req_stall, req_payload      | in        | valid & !stall
//  result  | rsp_valid, rsp_stall, rsp_payload      | out       | valid & !stall
//  config  | csr_valid, csr_ready, csr_index/_data  | in        | valid & ready
//
// Load, clear, swallowed xor steps and any request that fails a check answer from the
// request itself; a read answers from the registered store read. An xor step runs one
// word per cycle through both store read ports; each word is written back the cycle after.
// Reset is synchronous: it clears flags, operation state and result valid, and sets
// the counts to 16 shards of 1024 words; shard words stay undefined until written.
// A result held by rsp_stall holds req_stall high; the next request is taken in the
// cycle that result leaves, so one request is in flight at a time.

module xor_shard_recovery_engine #(
   parameter int MAX_SHARDS = xsre_pkg::DEF_MAX_SHARDS,
   parameter int MAX_WORDS  = xsre_pkg::DEF_MAX_WORDS,
   parameter int WORD_BITS  = xsre_pkg::DEF_WORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  xsre_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output xsre_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [xsre_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [xsre_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Commands down, status up; nothing else crosses between the two halves
   xsre_pkg::cmd_type       cmd;
   xsre_pkg::dp_status_type sts;

   // Sequencer: idle, read wait, xor word run, xor drain
   xsre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, flags, checks and result register
   xsre_datapath #(
      .MAX_SHARDS (MAX_SHARDS),
      .MAX_WORDS  (MAX_WORDS),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== tb/sv/xor_shard_recovery_engine_tb.sv =====
// xor_shard_recovery_engine_tb: self-checking regression bench for the XOR shard recovery engine.
// Depends on xsre_pkg and xor_shard_recovery_engine. A shadow shard store predicts each
// response, and responses are checked in order as the engine hands them over.

module xor_shard_recovery_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xsre_pkg::*;

   localparam int SHARDS        = DEF_MAX_SHARDS;
   localparam int WORDS         = DEF_MAX_WORDS;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 8;

   // Ways a recovery run is spoiled on purpose
   typedef enum int {
      FAULT_NONE, FAULT_NO_FIRST, FAULT_BAD_SOURCE, FAULT_OUT_PRESENT, FAULT_INTRUDER
   } fault_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   // Shadow of the engine: shard words, which words hold a written value, present flags,
   // the running xor operation and the two counts.
   bit   [63:0]       shard_words [SHARDS][WORDS];
   bit                word_set    [SHARDS][WORDS];
   bit   [SHARDS-1:0] present  = '0;
   logic [3:0]        cur_out  = '0;
   bit                aborted  = 1'b0;
   logic [4:0]        n_shards = SHARD_COUNT_RESET;
   logic [10:0]       n_words  = SHARD_WORDS_RESET;

   rsp_type answers_due [$];   // predicted responses, oldest first
   int      fail_count  = 0;
   int      items_done  = 0;   // requests of the current phase that the engine acts on
   int      cycle_count = 0;
   bit      calm        = 1'b0; // no gaps and no stalls while set
   int      stall_run   = 0;

   xor_shard_recovery_engine dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: far above the slowest legal run of this stimulus
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("xor_shard_recovery_engine regression: fail");
         $finish;
      end
   end

   function automatic int shard_limit();
      return (n_shards > SHARDS) ? SHARDS : int'(n_shards);
   endfunction

   function automatic int word_limit();
      return (n_words > WORDS) ? WORDS : int'(n_words);
   endfunction

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
   endfunction

   function automatic logic [63:0] word_pattern();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type make_req(logic [1:0] func, logic [3:0] shard,
                                        logic [3:0] source, logic [9:0] word,
                                        logic [63:0] data, logic first, logic last);
      req_type r;
      r.func       = func;
      r.shard      = shard;
      r.source     = source;
      r.word_index = word;
      r.data       = data;
      r.first      = first;
      r.last       = last;
      return r;
   endfunction

   // Xor step checks in the engine's order: output range, output present,
   // source range, source present. A source equal to the output is never present.
   function automatic logic [2:0] step_fault(logic [3:0] dst, logic [3:0] src);
      if (dst >= shard_limit()) return STATUS_SHARD_RANGE;
      if (present[dst]) return STATUS_OUT_PRESENT;
      if (src >= shard_limit()) return STATUS_SHARD_RANGE;
      if (!present[src]) return STATUS_SRC_MISSING;
      return STATUS_OK;
   endfunction

   // A continuation step of a failed operation is swallowed with an ok status
   function automatic bit skipped_step(req_type r);
      return r.func == FUNC_XOR && !r.first && aborted;
   endfunction

   // True when the request would make the engine read a word that was never written
   function automatic bit touches_blank_word(req_type r);
      logic [3:0] dst;
      dst = r.first ? r.shard : cur_out;
      if (r.func == FUNC_READ)
         return r.shard < shard_limit() && r.word_index < word_limit()
                && !word_set[r.shard][r.word_index];
      if (r.func != FUNC_XOR || skipped_step(r) || step_fault(dst, r.source) != STATUS_OK)
         return 1'b0;
      for (int w = 0; w < word_limit(); w++)
         if (!word_set[r.source][w] || (!r.first && !word_set[dst][w])) return 1'b1;
      return 1'b0;
   endfunction

   // Apply one request to the shadow store and return the response it earns
   function automatic rsp_type shard_engine_step(req_type r);
      rsp_type ans;
      ans = '0;
      case (r.func)
         FUNC_LOAD, FUNC_READ: begin
            if (r.shard >= shard_limit())
               ans.status = STATUS_SHARD_RANGE;
            else if (r.word_index >= word_limit())
               ans.status = STATUS_WORD_RANGE;
            else if (r.func == FUNC_READ)
               ans.read_data = shard_words[r.shard][r.word_index];
            else begin
               // a load overwrites even a present shard
               shard_words[r.shard][r.word_index] = r.data;
               word_set[r.shard][r.word_index]    = 1'b1;
               if (r.last) begin
                  present[r.shard] = 1'b1;
                  ans.op_done      = 1'b1;
               end
            end
         end
         FUNC_XOR: begin
            if (r.first) begin
               cur_out = r.shard;
               aborted = 1'b0;
            end
            if (r.first || !aborted) begin
               ans.status = step_fault(cur_out, r.source);
               if (ans.status != STATUS_OK)
                  aborted = 1'b1;
               else begin
                  // first step copies the source, later steps fold it in
                  for (int w = 0; w < word_limit(); w++) begin
                     shard_words[cur_out][w] = r.first ? shard_words[r.source][w]
                        : shard_words[cur_out][w] ^ shard_words[r.source][w];
                     word_set[cur_out][w] = 1'b1;
                  end
                  if (r.last) begin
                     present[cur_out] = 1'b1;
                     ans.op_done      = 1'b1;
                  end
               end
            end
         end
         default: present = '0;   // clear keeps the xor operation state
      endcase
      return ans;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int sl, wl;
      sl = shard_limit();
      wl = word_limit();
      case ($urandom_range(9))
         0, 1, 2: r.func = FUNC_LOAD;
         3, 4, 5: r.func = FUNC_XOR;
         6, 7, 8: r.func = FUNC_READ;
         default: r.func = FUNC_CLEAR;
      endcase
      // lean toward indices in range, keep some anywhere in the field
      r.shard      = (sl > 0 && $urandom_range(3) != 0) ? 4'($urandom_range(sl - 1)) : 4'($urandom);
      r.source     = (sl > 0 && $urandom_range(3) != 0) ? 4'($urandom_range(sl - 1)) : 4'($urandom);
      r.word_index = (wl > 0 && $urandom_range(3) != 0) ? 10'($urandom_range(wl - 1))
                                                        : 10'($urandom);
      r.data       = word_pattern();
      r.first      = 1'($urandom);
      r.last       = 1'($urandom);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
   endtask

   // Hand one request to the engine and record the response it must produce.
   // Enter at a rising edge; return at the edge where the request was taken.
   task automatic send_request(req_type r);
      int gap;
      bit taken;
      // never let the engine read a word that holds no value: turn such a request
      // into a plain word load instead
      if (touches_blank_word(r)) begin
         r.func = FUNC_LOAD;
         r.last = 1'b0;
      end
      gap = (calm || $urandom_range(9) < 6) ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      // stall settles after the edge, so sample it mid-cycle
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      if (!skipped_step(r)) items_done++;
      answers_due.push_back(shard_engine_step(r));
   endtask

   // Drop valid and hold until every predicted response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic quiesce();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      if (index == REG_SHARD_COUNT)
         n_shards = value[4:0];
      else if (index == REG_SHARD_WORDS)
         n_words = value[10:0];
      @(posedge clock);
   endtask

   // Receiver side: random stall runs, released entirely while calm
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if ($urandom_range(99) < 35) begin
         rsp_stall <= 1'b1;
         stall_run <= idle_length();
      end else begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(8);
      end
   end

   // Response checker: payload and stall are stable mid-cycle, and a response seen
   // here is taken at the next rising edge.
   always @(negedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            fail_count++;
            $display("%0t: response with none expected, status %0d data %h done %b",
                     $time, rsp_payload.status, rsp_payload.read_data, rsp_payload.op_done);
         end else begin
            want = answers_due.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", want.status, rsp_payload.status);
            if (rsp_payload.read_data !== want.read_data)
               report_mismatch("read_data", want.read_data, rsp_payload.read_data);
            if (rsp_payload.op_done !== want.op_done)
               report_mismatch("op_done", want.op_done, rsp_payload.op_done);
         end
      end
   end

   // Power-on counts: sixteen shards of 1024 words, top indices in range
   task automatic test_reset_defaults();
      send_request(make_req(FUNC_LOAD, 4'd15, 4'd0, 10'd1023, '1, 1'b0, 1'b1));
      send_request(make_req(FUNC_READ, 4'd15, 4'd0, 10'd1023, '0, 1'b0, 1'b0));
      send_request(make_req(FUNC_LOAD, 4'd0, 4'd15, 10'd0, '0, 1'b1, 1'b0));
      send_request(make_req(FUNC_READ, 4'd0, 4'd0, 10'd0, '1, 1'b0, 1'b0));
      // shard 15 is present: refuse an xor into it before looking at the source
      send_request(make_req(FUNC_XOR, 4'd15, 4'd3, 10'd0, '0, 1'b1, 1'b1));
      send_request(make_req(FUNC_CLEAR, 4'd0, 4'd0, 10'd0, '0, 1'b0, 1'b0));
   endtask

   // Shard range is checked ahead of word range on loads and reads
   task automatic test_range_checks();
      quiesce();
      csr_write(REG_SHARD_COUNT, 16'd2);
      csr_write(REG_SHARD_WORDS, 16'd1);
      send_request(make_req(FUNC_LOAD, 4'd2, 4'd0, 10'd0, word_pattern(), 1'b0, 1'b1));
      send_request(make_req(FUNC_LOAD, 4'd1, 4'd0, 10'd1, word_pattern(), 1'b0, 1'b1));
      send_request(make_req(FUNC_LOAD, 4'd3, 4'd0, 10'd7, word_pattern(), 1'b0, 1'b0));
      send_request(make_req(FUNC_READ, 4'd0, 4'd0, 10'd5, '0, 1'b0, 1'b0));
      send_request(make_req(FUNC_READ, 4'd2, 4'd0, 10'd0, '0, 1'b0, 1'b0));
      send_request(make_req(FUNC_LOAD, 4'd1, 4'd0, 10'd0, word_pattern(), 1'b0, 1'b1));
   endtask

   // Every xor step status and a swallowed continuation on a small store of four two-word shards
   task automatic test_xor_steps();
      quiesce();
      csr_write(REG_SHARD_COUNT, 16'd4);
      csr_write(REG_SHARD_WORDS, 16'd2);
      send_request(make_req(FUNC_LOAD, 4'd0, 4'd0, 10'd0, word_pattern(), 1'b0, 1'b0));
      send_request(make_req(FUNC_LOAD, 4'd0, 4'd0, 10'd1, word_pattern(), 1'b0, 1'b1));
      send_request(make_req(FUNC_LOAD, 4'd1, 4'd0, 10'd0, word_pattern(), 1'b0, 1'b0));
      send_request(make_req(FUNC_LOAD, 4'd1, 4'd0, 10'd1, word_pattern(), 1'b0, 1'b1));
      // output already present aborts; the continuation is then swallowed
      send_request(make_req(FUNC_XOR, 4'd0, 4'd1, 10'd0, '0, 1'b1, 1'b0));
      send_request(make_req(FUNC_XOR, 4'd2, 4'd1, 10'd0, '0, 1'b0, 1'b1));
      // source equal to output reads as missing
      send_request(make_req(FUNC_XOR, 4'd2, 4'd2, 10'd0, '0, 1'b1, 1'b1));
      send_request(make_req(FUNC_XOR, 4'd2, 4'd9, 10'd0, '0, 1'b1, 1'b1));
      send_request(make_req(FUNC_XOR, 4'd6, 4'd0, 10'd0, '0, 1'b1, 1'b1));
      // rebuild shard 3; the second step ignores its shard field and continues
      send_request(make_req(FUNC_XOR, 4'd3, 4'd0, 10'd0, '0, 1'b1, 1'b0));
      send_request(make_req(FUNC_XOR, 4'd12, 4'd1, 10'd0, '0, 1'b0, 1'b1));
      send_request(make_req(FUNC_READ, 4'd3, 4'd0, 10'd1, '0, 1'b0, 1'b0));
   endtask

   task automatic run_noise();
      int n;
      n = $urandom_range(8, 1);
      repeat (n) send_request(random_request());
   endtask

   // One erasure recovery: clear, load the surviving shards in full, xor them into a
   // missing shard, read some of it back. Now and then spoil the run.
   task automatic run_recovery();
      logic [3:0]      member [4];
      bit [SHARDS-1:0] used;
      int              sl, wl, n, pick, spoil;
      fault_type       fault;
      req_type         r;
      sl   = shard_limit();
      wl   = word_limit();
      n    = $urandom_range((sl > 4) ? 3 : sl - 1, 1);
      used = '0;
      // member[0..n-1] are the sources, member[n] the shard to rebuild
      for (int k = 0; k <= n; k++) begin
         do pick = $urandom_range(sl - 1); while (used[pick]);
         used[pick] = 1'b1;
         member[k]  = 4'(pick);
      end
      fault = FAULT_NONE;
      if ($urandom_range(3) == 0)
         fault = fault_type'($urandom_range(FAULT_INTRUDER, FAULT_NO_FIRST));
      spoil = $urandom_range(n - 1);

      send_request(make_req(FUNC_CLEAR, 4'($urandom), 4'($urandom), 10'($urandom),
                            word_pattern(), 1'($urandom), 1'($urandom)));
      for (int k = 0; k < n; k++)
         for (int w = 0; w < wl; w++)
            send_request(make_req(FUNC_LOAD, member[k], 4'($urandom), 10'(w), word_pattern(),
                                  1'($urandom), w == wl - 1));
      if (fault == FAULT_OUT_PRESENT)
         send_request(make_req(FUNC_LOAD, member[n], 4'($urandom), 10'($urandom_range(wl - 1)),
                               word_pattern(), 1'b0, 1'b1));
      // hold the sender off until the engine has answered everything
      if ($urandom_range(6) == 0) wait_drained();

      for (int k = 0; k < n; k++) begin
         if (fault == FAULT_INTRUDER && k == spoil) send_request(random_request());
         r = make_req(FUNC_XOR, (k == 0) ? member[n] : 4'($urandom), member[k], 10'($urandom),
                      word_pattern(), k == 0, k == n - 1);
         if (fault == FAULT_NO_FIRST && k == 0) r.first = 1'b0;
         if (fault == FAULT_BAD_SOURCE && k == spoil) r.source = 4'($urandom);
         send_request(r);
      end
      repeat ($urandom_range(3, 1))
         send_request(make_req(FUNC_READ, member[n], 4'($urandom), 10'($urandom_range(wl - 1)),
                               word_pattern(), 1'($urandom), 1'($urandom)));
   endtask

   // Reconfigure while idle, then run recoveries and noise until the phase has
   // fed the engine enough requests it acts on
   task automatic run_phase(int shard_cnt, int word_cnt, int quota, bit quiet);
      quiesce();
      // junk in the unused upper data bits must be ignored
      csr_write(REG_SHARD_COUNT, {11'($urandom), 5'(shard_cnt)});
      csr_write(REG_SHARD_WORDS, {5'($urandom), 11'(word_cnt)});
      calm <= quiet;
      items_done = 0;
      while (items_done < quota) begin
         if (shard_limit() >= 2 && word_limit() >= 1 && word_limit() <= 16
             && $urandom_range(99) < 60)
            run_recovery();
         else
            run_noise();
      end
   endtask

   // Small shards for the bulk; zero, oversized and full-size counts for the edges
   task automatic test_random_phases();
      run_phase(16, 4, 85, 1'b0);
      run_phase(3, 1, 60, 1'b1);
      run_phase(31, 6, 85, 1'b0);
      run_phase(0, 3, 15, 1'b0);
      run_phase(16, 2047, 35, 1'b0);
      run_phase(2, 16, 65, 1'b0);
      run_phase(9, 0, 15, 1'b0);
      run_phase(1, 5, 15, 1'b0);
      run_phase(16, 1024, 35, 1'b0);
      run_phase(5, 8, 75, 1'b0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_range_checks();
      test_xor_steps();
      test_random_phases();
      // let the last xor write-back finish before judging
      wait_drained();
      repeat (word_limit() + SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && answers_due.size() == 0)
         $display("xor_shard_recovery_engine regression: pass");
      else
         $display("xor_shard_recovery_engine regression: fail");
      $finish;
   end

endmodule
